[hdl/npts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npts_pkg: shared types and constants of the nearest point table search
// Beat types, command codes, table sizes and the distance helper.
// ----------------------------------------------------------------------------
package npts_pkg;

  // Table and coordinate geometry
  localparam int MAX_POINTS  = 64;
  localparam int COORD_W     = 16;
  localparam int IDX_W       = $clog2(MAX_POINTS);
  localparam int COUNT_W     = $clog2(MAX_POINTS + 1);
  localparam int SQ_W        = 2 * COORD_W;
  localparam int DIST_W      = 2 * COORD_W + 4;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  // Input beat
  typedef struct packed {
    logic                      action;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } item_t;

  // Result beat
  typedef struct packed {
    logic [IDX_W-1:0]   nearest_index;
    logic               nearest_valid;
    logic               insert_rejected;
    logic [COUNT_W-1:0] point_total;
  } result_t;

  // Decoded command held in the queue
  typedef struct packed {
    op_e    op;
    point_t pos;
  } cmd_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // Magnitude of a - b; always fits COORD_W unsigned bits
  function automatic logic [COORD_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                  input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    logic        [COORD_W:0] mag;
    d   = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    mag = d[COORD_W] ? -d : d;
    return mag[COORD_W-1:0];
  endfunction

endpackage

[hdl/nearest_point_table_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_point_table_search: 3D snap point table with nearest-point search
// Stores up to 64 points and finds the stored point closest to a query.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive item_i and raise start_i; the beat is taken at a
//   rising edge where start_i is high and busy_o is low. action 0 appends
//   the position to the table, action 1 searches for the nearest point.
//   Result channel: done_o is high for exactly one cycle with result_o; the
//   receiver cannot stall it, so it must capture the beat in that cycle.
//   Every command gives exactly one result, in command order.
// Timing:
//   A two-entry command queue sits between intake and the search engine,
//   so up to two commands are taken while the engine is busy.
//   Insert, or query on an empty table: the result is registered as soon as
//   the engine pops the command in idle. Query on N stored points: the
//   engine reads one point per cycle from the point memory, then a
//   four-stage distance pipeline drains; the result is registered when the
//   last point leaves it, and the engine then returns to idle.
// Reset:
//   rst_ni clears the point count and the queue; busy_o is high during reset
//   and until the intake flag seen_q is registered high after it.
// ----------------------------------------------------------------------------
module nearest_point_table_search import npts_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  item_t   item_i,
  output logic    busy_o,
  output logic    done_o,
  output result_t result_o
);

  queue_stat_t stat;
  logic        push;
  logic        pop;
  cmd_t        cmd;
  cmd_t        head;

  // Intake and classify
  npts_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .item_i  (item_i),
    .busy_o  (busy_o),
    .stat_i  (stat),
    .push_o  (push),
    .cmd_o   (cmd)
  );

  // Decouple intake from the engine
  npts_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (stat)
  );

  // Execute commands
  npts_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .stat_i   (stat),
    .pop_o    (pop),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

[hdl/npts_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npts_front: command intake
// Accepts input beats, decodes the action into a command and pushes it.
// ----------------------------------------------------------------------------
module npts_front import npts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  item_t       item_i,
  output logic        busy_o,
  input  queue_stat_t stat_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  logic seen_q;
  logic seen_d;

  // Hold off new beats while the queue is full or coming out of reset
  assign busy_o = stat_i.full | ~seen_q;
  assign push_o = start_i & ~busy_o;

  // Classify the beat
  always_comb begin
    cmd_o.op    = item_i.action ? OP_QUERY : OP_INSERT;
    cmd_o.pos.x = item_i.pos_x;
    cmd_o.pos.y = item_i.pos_y;
    cmd_o.pos.z = item_i.pos_z;
  end

  // Open intake once seen_q is registered high after reset release
  assign seen_d = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else begin
      seen_q <= seen_d;
    end
  end

endmodule

[hdl/npts_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npts_queue: command queue
// Short FIFO that decouples the intake from the search engine.
// ----------------------------------------------------------------------------
module npts_queue import npts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  cmd_t        cmd_i,
  input  logic        pop_i,
  output cmd_t        head_o,
  output queue_stat_t stat_o
);

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] fill_q, fill_d;
  logic              do_push;
  logic              do_pop;

  assign stat_o.full  = (fill_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (fill_q == '0);
  assign head_o       = entry_q[rd_ptr_q];

  assign do_push = push_i & ~stat_o.full;
  assign do_pop  = pop_i & ~stat_o.empty;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   fill_d = fill_q + QCNT_W'(1);
      2'b01:   fill_d = fill_q - QCNT_W'(1);
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

[hdl/npts_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npts_back: point table and search engine
// Executes inserts into the point memory and runs the pipelined linear
// nearest-point scan for queries; drives the result beat.
// ----------------------------------------------------------------------------
module npts_back import npts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        head_i,
  input  queue_stat_t stat_i,
  output logic        pop_o,
  output logic        done_o,
  output result_t     result_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_DRAIN = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0]   scan_idx_q, scan_idx_d;
  point_t             query_q, query_d;
  logic               wr_en;
  logic               issue;
  logic               issue_last;
  logic               start_scan;

  // Point memory
  point_t             mem_q [MAX_POINTS];
  point_t             rdata_q;

  // Scan pipeline
  logic               p1_vld_q, p2_vld_q, p3_vld_q, p4_vld_q;
  logic               p1_last_q, p2_last_q, p3_last_q, p4_last_q;
  logic [IDX_W-1:0]   p1_idx_q, p2_idx_q, p3_idx_q, p4_idx_q;
  logic [COORD_W-1:0] ad_x_q, ad_y_q, ad_z_q;
  logic [SQ_W-1:0]    sq_x_q, sq_y_q, sq_z_q;
  logic [DIST_W-1:0]  dist_q;

  // Running minimum
  logic [DIST_W-1:0]  best_q;
  logic [IDX_W-1:0]   best_idx_q;
  logic               have_best_q;
  logic               better;

  // Result register
  logic               res_vld_q, res_vld_d;
  result_t            res_q, res_d;

  assign better = p4_vld_q & (~have_best_q | (dist_q < best_q));
  assign issue_last = (COUNT_W'(scan_idx_q) == (count_q - COUNT_W'(1)));

  // Sequence commands
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    scan_idx_d = scan_idx_q;
    query_d    = query_q;
    pop_o      = 1'b0;
    wr_en      = 1'b0;
    issue      = 1'b0;
    start_scan = 1'b0;
    res_vld_d  = 1'b0;
    res_d      = res_q;
    case (state_q)
      S_IDLE: begin
        if (!stat_i.empty) begin
          pop_o = 1'b1;
          res_d.nearest_index   = '0;
          res_d.nearest_valid   = 1'b0;
          res_d.insert_rejected = 1'b0;
          res_d.point_total     = count_q;
          if (head_i.op == OP_INSERT) begin
            res_vld_d = 1'b1;
            if (count_q == COUNT_W'(MAX_POINTS)) begin
              res_d.insert_rejected = 1'b1;
            end else begin
              wr_en             = 1'b1;
              count_d           = count_q + COUNT_W'(1);
              res_d.point_total = count_d;
            end
          end else if (count_q == '0) begin
            res_vld_d = 1'b1;
          end else begin
            query_d    = head_i.pos;
            scan_idx_d = '0;
            start_scan = 1'b1;
            state_d    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        issue = 1'b1;
        if (issue_last) begin
          state_d = S_DRAIN;
        end else begin
          scan_idx_d = scan_idx_q + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        if (p4_vld_q && p4_last_q) begin
          res_vld_d             = 1'b1;
          res_d.nearest_index   = better ? p4_idx_q : best_idx_q;
          res_d.nearest_valid   = 1'b1;
          res_d.insert_rejected = 1'b0;
          res_d.point_total     = count_q;
          state_d               = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_idx_q  <= '0;
      p1_vld_q    <= 1'b0;
      p2_vld_q    <= 1'b0;
      p3_vld_q    <= 1'b0;
      p4_vld_q    <= 1'b0;
      have_best_q <= 1'b0;
      res_vld_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      scan_idx_q <= scan_idx_d;
      p1_vld_q   <= issue;
      p2_vld_q   <= p1_vld_q;
      p3_vld_q   <= p2_vld_q;
      p4_vld_q   <= p3_vld_q;
      res_vld_q  <= res_vld_d;
      if (start_scan) begin
        have_best_q <= 1'b0;
      end else if (better) begin
        have_best_q <= 1'b1;
      end
    end
  end

  // Write inserts and read the point under scan
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[IDX_W-1:0]] <= head_i.pos;
    end
    if (issue) begin
      rdata_q <= mem_q[scan_idx_q];
    end
  end

  // Distance pipeline: difference, square, sum
  always_ff @(posedge clk_i) begin
    query_q   <= query_d;
    p1_last_q <= issue_last;
    p1_idx_q  <= scan_idx_q;

    p2_last_q <= p1_last_q;
    p2_idx_q  <= p1_idx_q;
    ad_x_q    <= abs_diff(query_q.x, rdata_q.x);
    ad_y_q    <= abs_diff(query_q.y, rdata_q.y);
    ad_z_q    <= abs_diff(query_q.z, rdata_q.z);

    p3_last_q <= p2_last_q;
    p3_idx_q  <= p2_idx_q;
    sq_x_q    <= SQ_W'(ad_x_q) * SQ_W'(ad_x_q);
    sq_y_q    <= SQ_W'(ad_y_q) * SQ_W'(ad_y_q);
    sq_z_q    <= SQ_W'(ad_z_q) * SQ_W'(ad_z_q);

    p4_last_q <= p3_last_q;
    p4_idx_q  <= p3_idx_q;
    dist_q    <= DIST_W'(sq_x_q) + DIST_W'(sq_y_q) + DIST_W'(sq_z_q);

    res_q     <= res_d;
  end

  // Keep the strictly smaller distance; earliest point wins a tie
  always_ff @(posedge clk_i) begin
    if (better) begin
      best_q     <= dist_q;
      best_idx_q <= p4_idx_q;
    end
  end

  assign done_o   = res_vld_q;
  assign result_o = res_q;

endmodule

[hdl/npts_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npts_checker: port-level checks of the nearest point table search
// Watches result beats for consistency of flags, index and point total.
// ----------------------------------------------------------------------------
module npts_checker import npts_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    done_o,
  input result_t result_o
);

  // A found point lies inside the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.nearest_valid |->
      !result_o.insert_rejected &&
      (COUNT_W'(result_o.nearest_index) < result_o.point_total))
    else $error("nearest index outside stored points");

  // A rejected insert only happens on a full table and reports no point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.insert_rejected |->
      (result_o.point_total == COUNT_W'(MAX_POINTS)) &&
      !result_o.nearest_valid && (result_o.nearest_index == '0))
    else $error("bad rejected insert beat");

  // Point total never exceeds the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.point_total <= COUNT_W'(MAX_POINTS)))
    else $error("point total above table size");

  // No result beat is present as reset is released
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !done_o)
    else $error("result beat right after reset");

endmodule

bind nearest_point_table_search npts_checker u_npts_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .done_o   (done_o),
  .result_o (result_o)
);
